>>> src/tarev_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tarev_pkg;

    // Tensor geometry
    localparam int NUM_AXES   = 4;
    localparam int MAX_RANK   = 4;
    localparam int RANK_CAP   = (MAX_RANK < NUM_AXES) ? MAX_RANK : NUM_AXES;
    localparam int ADDR_BITS  = 20;
    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int RANK_W     = 3;
    localparam int SIZE_LIMIT = 1024;
    localparam int IDX_PROD_W = IDX_W + ADDR_BITS;

    // Arithmetic
    localparam int VALUE_W    = 32;
    localparam int COEFF_W    = 16;
    localparam int PROD_W     = VALUE_W + COEFF_W;
    localparam int FRAC_SHIFT = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Stream payloads
    localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_W       = ADDR_BITS + VALUE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

    // Each stride depends on the one below it, so the chain is rebuilt one axis at a time.
    localparam int SETTLE_CYCLES = NUM_AXES - 1;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RANK        = 3'd0,
        REG_SIZE_0      = 3'd1,
        REG_SIZE_1      = 3'd2,
        REG_SIZE_2      = 3'd3,
        REG_SIZE_3      = 3'd4,
        REG_SCALE_COEFF = 3'd5
    } cfg_reg_t;

    // Rank and sizes after clamping to their legal ranges.
    typedef struct packed {
        logic [RANK_W-1:0]                rank;
        logic [NUM_AXES-1:0][SIZE_W-1:0] size;
    } tensor_shape_t;

    // Odometer position of the element being accepted. Axes beyond the rank read as zero.
    typedef struct packed {
        logic [NUM_AXES-1:0][IDX_W-1:0] idx;
        logic                            last;
    } odo_status_t;

    function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] r);
        logic [RANK_W-1:0] res;
        res = r;
        if (r == '0)
            res = RANK_W'(1);
        else if (r > RANK_W'(RANK_CAP))
            res = RANK_W'(RANK_CAP);
        return res;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] res;
        res = s;
        if (s == '0)
            res = SIZE_W'(1);
        else if (s > SIZE_W'(SIZE_LIMIT))
            res = SIZE_W'(SIZE_LIMIT);
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/tarev_odometer.sv
`timescale 1ns / 1ps
`default_nettype none

module tarev_odometer
    import tarev_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire tensor_shape_t shape,
    output odo_status_t        status
);

    logic [NUM_AXES-1:0][IDX_W-1:0] idx_reg;
    logic [NUM_AXES-1:0][IDX_W-1:0] idx_next;
    logic [NUM_AXES-1:0]            in_use;
    logic [NUM_AXES-1:0]            at_end;
    logic [NUM_AXES-1:0]            carry;
    logic                           last;

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            in_use[k] = (RANK_W'(k) < shape.rank);
            // An index past its axis end (sizes shrunk mid-tensor) counts as the end.
            at_end[k] = !in_use[k] ||
                        (({1'b0, idx_reg[k]} + SIZE_W'(1)) >= shape.size[k]);
        end

        // Axis k moves only when every faster axis is at its end.
        carry[NUM_AXES-1] = 1'b1;
        for (int k = NUM_AXES - 2; k >= 0; k--)
            carry[k] = carry[k+1] & at_end[k+1];

        last = &at_end;

        idx_next = idx_reg;
        if (step)
        begin
            if (last)
                idx_next = '0;
            else
            begin
                for (int k = 0; k < NUM_AXES; k++)
                    if (in_use[k] && carry[k])
                        idx_next[k] = at_end[k] ? '0 : idx_reg[k] + IDX_W'(1);
            end
        end

        for (int k = 0; k < NUM_AXES; k++)
            status.idx[k] = in_use[k] ? idx_reg[k] : '0;
        status.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

>>> src/tensor_axis_reverse_transpose_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Axis-reversing transpose address generator with scaling. Elements of a tensor of rank 1 to 4
// arrive on the slave stream in row-major source order (axis 0 slowest). For each one the
// master stream returns the element's linear address in the tensor with all axes reversed,
// i0 + i1*s0 + i2*s0*s1 + ..., wrapped to 20 bits, and the element times the Q8.8 coefficient,
// floored and saturated to 32 bits, with tlast on the final element of the tensor. The block
// takes one element per clock cycle while the strides are settled and the output is not
// stalled. One register holds the per-axis stride products and the value times coefficient,
// the next holds the summed address and the saturated value. The result register decouples
// the two sides, so a new element can enter the first register while a finished result waits.
// The per-axis strides are kept in registers that are rebuilt from the sizes one axis per
// cycle, so after every configuration write the slave side holds tready low until they settle.
// Configuration writes are taken on every cycle and must only be issued while no element is in
// flight. Rank 0 acts as 1, a rank above 4 as 4, a size of 0 as 1 and a size above 1024 as 1024.

module tensor_axis_reverse_transpose_unit
    import tarev_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // Configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    // Source elements
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [31:0] value

    // Results
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,   // [19:0] dest_addr,
                                                         // [51:20] scaled_value, [55:52] zero
    output logic                         m_axis_tlast    // last
);

    // Configuration registers
    logic [RANK_W-1:0]                rank_reg;
    logic [NUM_AXES-1:0][SIZE_W-1:0] size_reg;
    logic signed [COEFF_W-1:0]        scale_coeff_reg;

    // Stride chain
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] stride_reg;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] stride_next;
    logic [SETTLE_W-1:0]                settle_reg;
    logic [SETTLE_W-1:0]                settle_next;

    // First pipeline stage
    logic                               a_valid_reg;
    logic                               a_valid_next;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] a_prod_reg;
    logic [NUM_AXES-1:0][ADDR_BITS-1:0] a_prod_next;
    logic signed [PROD_W-1:0]           a_mult_reg;
    logic signed [PROD_W-1:0]           a_mult_next;
    logic                               a_last_reg;

    // Result register
    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [ADDR_BITS-1:0]               m_addr_reg;
    logic [ADDR_BITS-1:0]               m_addr_next;
    logic [VALUE_W-1:0]                 m_value_reg;
    logic [VALUE_W-1:0]                 m_value_next;
    logic                               m_last_reg;

    logic                               cfg_write;
    logic                               s_accept;
    logic                               out_ready;
    logic                               a_advance;
    tensor_shape_t                      shape;
    odo_status_t                        odo;
    logic [NUM_AXES-1:0][IDX_PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0]           shifted;
    logic [PROD_W-VALUE_W:0]            upper;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= RANK_W'(2);
            size_reg        <= {NUM_AXES{SIZE_W'(1)}};
            scale_coeff_reg <= COEFF_W'(256);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANK:        rank_reg        <= cfg_data[RANK_W-1:0];
                REG_SIZE_0:      size_reg[0]     <= cfg_data[SIZE_W-1:0];
                REG_SIZE_1:      size_reg[1]     <= cfg_data[SIZE_W-1:0];
                REG_SIZE_2:      size_reg[2]     <= cfg_data[SIZE_W-1:0];
                REG_SIZE_3:      size_reg[3]     <= cfg_data[SIZE_W-1:0];
                REG_SCALE_COEFF: scale_coeff_reg <= cfg_data[COEFF_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        shape.rank = eff_rank(rank_reg);
        for (int k = 0; k < NUM_AXES; k++)
            shape.size[k] = eff_size(size_reg[k]);
    end

    // Stride k is the product of the sizes of axes below k, modulo the address range.
    // Each cycle one more axis of the chain picks up the new sizes.
    always_comb
    begin
        stride_next[0] = ADDR_BITS'(1);
        for (int k = 1; k < NUM_AXES; k++)
            stride_next[k] = ADDR_BITS'(stride_reg[k-1] * ADDR_BITS'(shape.size[k-1]));

        if (cfg_write)
            settle_next = SETTLE_W'(SETTLE_CYCLES);
        else if (settle_reg != '0)
            settle_next = settle_reg - SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= {NUM_AXES{ADDR_BITS'(1)}};
            settle_reg <= '0;
        end
        else
        begin
            stride_reg <= stride_next;
            settle_reg <= settle_next;
        end
    end

    // Handshake: the result register frees the pipeline whenever it is empty or being taken.
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign a_advance     = a_valid_reg && out_ready;
    assign s_axis_tready = (settle_reg == '0) && (!a_valid_reg || out_ready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    tarev_odometer u_odometer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s_accept),
        .shape  (shape),
        .status (odo)
    );

    // First stage: one index-times-stride product per axis and the scale multiplication.
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            prod_full[k]   = IDX_PROD_W'(odo.idx[k]) * IDX_PROD_W'(stride_reg[k]);
            a_prod_next[k] = prod_full[k][ADDR_BITS-1:0];
        end
        a_mult_next = PROD_W'($signed(s_axis_tdata[VALUE_W-1:0])) * PROD_W'(scale_coeff_reg);

        if (s_accept)
            a_valid_next = 1'b1;
        else if (a_advance)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_prod_reg <= a_prod_next;
            a_mult_reg <= a_mult_next;
            a_last_reg <= odo.last;
        end
    end

    // Second stage: address sum, and floor shift with saturation to 32 bits.
    always_comb
    begin
        m_addr_next = '0;
        for (int k = 0; k < NUM_AXES; k++)
            m_addr_next = m_addr_next + a_prod_reg[k];

        // The arithmetic shift rounds toward minus infinity.
        shifted = a_mult_reg >>> FRAC_SHIFT;
        upper   = shifted[PROD_W-1:VALUE_W-1];
        if ((&upper) || !(|upper))
            m_value_next = shifted[VALUE_W-1:0];
        else if (shifted[PROD_W-1])
            m_value_next = {1'b1, {(VALUE_W-1){1'b0}}};
        else
            m_value_next = {1'b0, {(VALUE_W-1){1'b1}}};

        if (a_advance)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            m_addr_reg  <= m_addr_next;
            m_value_reg <= m_value_next;
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_value_reg, m_addr_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> src/tarev_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tarev_checker
    import tarev_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_valid,
    input wire logic                   cfg_ready,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed or vanished while stalled");

    // The stride chain must settle before the next element is taken.
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=>
            !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("element taken before strides settled");

    // A result appearing on an empty output comes from an earlier input transfer.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transfer");

endmodule

bind tensor_axis_reverse_transpose_unit tarev_checker u_tarev_checker (.*);

`default_nettype wire
